FILE: rtl/core/four_sensor_sun_tracker_assert.svh
// Assertion macros used by the sun tracker checker.
`ifndef FOUR_SENSOR_SUN_TRACKER_ASSERT_SVH
`define FOUR_SENSOR_SUN_TRACKER_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define FSST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define FSST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/fsst_pkg.sv
`timescale 1ns / 1ps

package fsst_pkg;

    // Field widths
    localparam int LIGHT_BITS = 10;
    localparam int ANGLE_BITS = 8;

    // Low sample bits that take part in quantizing
    localparam int SAMPLE_BITS = 10;
    localparam int SAMPLE_USED = (SAMPLE_BITS < LIGHT_BITS) ? SAMPLE_BITS : LIGHT_BITS;

    // Quantizer: floor(x / 100) as a multiply by a rounded-up reciprocal.
    // With the shift at sample width plus clog2(100), the result is exact.
    localparam int QUANT_DIV   = 100;
    localparam int QUANT_EXTRA = $clog2(QUANT_DIV);
    localparam int QUANT_SHIFT = SAMPLE_USED + QUANT_EXTRA;
    localparam int MULT_BITS   = SAMPLE_USED + 1;
    localparam int PROD_BITS   = SAMPLE_USED + MULT_BITS;
    localparam logic [MULT_BITS-1:0] QUANT_MULT =
        MULT_BITS'(((64'd1 << QUANT_SHIFT) + 64'(QUANT_DIV) - 64'd1) / 64'(QUANT_DIV));
    localparam int Q_BITS = $clog2((2 ** SAMPLE_USED - 1) / QUANT_DIV + 1);

    // Reset values
    localparam logic [ANGLE_BITS-1:0] PAN_LIMIT_RESET  = ANGLE_BITS'(160);
    localparam logic [ANGLE_BITS-1:0] TILT_LIMIT_RESET = ANGLE_BITS'(180);
    localparam logic [ANGLE_BITS-1:0] PAN_RESET        = ANGLE_BITS'(80);
    localparam logic [ANGLE_BITS-1:0] TILT_RESET       = ANGLE_BITS'(0);

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PAN_LIMIT  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TILT_LIMIT = 1'b1;

    typedef struct packed {
        logic [LIGHT_BITS-1:0] light_a;
        logic [LIGHT_BITS-1:0] light_b;
        logic [LIGHT_BITS-1:0] light_c;
        logic [LIGHT_BITS-1:0] light_d;
    } light_set_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] pan_angle;
        logic [ANGLE_BITS-1:0] tilt_angle;
    } angle_set_t;

    // Quantize one raw sample to tenths of full scale (divide by 100)
    function automatic logic [Q_BITS-1:0] quantize(input logic [LIGHT_BITS-1:0] raw);
        logic [PROD_BITS-1:0] prod;
        prod = {{MULT_BITS{1'b0}}, raw[SAMPLE_USED-1:0]}
             * {{SAMPLE_USED{1'b0}}, QUANT_MULT};
        return Q_BITS'(prod >> QUANT_SHIFT);
    endfunction

endpackage

FILE: rtl/core/four_sensor_sun_tracker.sv
`timescale 1ns / 1ps

// Four-sensor sun tracker. Each beat on the input carries four raw light
// samples; each is divided by 100, and every sensor below the brightest one
// counts as dim. The pan angle steps down by one when sensors one and two are
// dim and up when three and four are; the tilt angle steps up when two and
// three are dim and down when one and four are. Angles stop at zero and at the
// pan_limit / tilt_limit registers (reset 160 and 180; start angles 80 and 0).
// Every input beat yields one output beat with both new angles. The block
// takes one sample set per clock: an input register feeds combinational
// quantize, four-way maximum and saturating step logic into the result
// register, and the pipeline only stalls when the result register is held
// by out_stall.
// Write the limit registers only while no beat is in flight.
module four_sensor_sun_tracker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  fsst_pkg::light_set_t                 in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output fsst_pkg::angle_set_t                 out_data,
    input  logic                                 cfg_we,
    input  logic [fsst_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [fsst_pkg::ANGLE_BITS-1:0]      cfg_data
);

    logic                             in_valid_reg;
    logic                             in_valid_next;
    fsst_pkg::light_set_t             sample_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [fsst_pkg::ANGLE_BITS-1:0]  pan_pos_reg;
    logic [fsst_pkg::ANGLE_BITS-1:0]  pan_pos_next;
    logic [fsst_pkg::ANGLE_BITS-1:0]  tilt_pos_reg;
    logic [fsst_pkg::ANGLE_BITS-1:0]  tilt_pos_next;
    logic [fsst_pkg::ANGLE_BITS-1:0]  pan_limit_reg;
    logic [fsst_pkg::ANGLE_BITS-1:0]  tilt_limit_reg;

    logic                             out_blocked;
    logic                             advance;
    logic                             in_take;
    logic [fsst_pkg::Q_BITS-1:0]      q1;
    logic [fsst_pkg::Q_BITS-1:0]      q2;
    logic [fsst_pkg::Q_BITS-1:0]      q3;
    logic [fsst_pkg::Q_BITS-1:0]      q4;
    logic [fsst_pkg::Q_BITS-1:0]      max12;
    logic [fsst_pkg::Q_BITS-1:0]      max34;
    logic [fsst_pkg::Q_BITS-1:0]      top;
    logic                             d1;
    logic                             d2;
    logic                             d3;
    logic                             d4;
    logic [fsst_pkg::ANGLE_BITS-1:0]  pan_dn;
    logic [fsst_pkg::ANGLE_BITS-1:0]  tilt_up;

    // Pipeline flow control
    assign out_blocked = out_valid_reg && out_stall;
    assign advance     = in_valid_reg && !out_blocked;
    assign in_stall    = in_valid_reg && out_blocked;
    assign in_take     = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
        out_valid_next = advance || out_blocked;
    end

    // Quantize and find the brightest sensor
    always_comb
    begin
        q1    = fsst_pkg::quantize(sample_reg.light_a);
        q2    = fsst_pkg::quantize(sample_reg.light_b);
        q3    = fsst_pkg::quantize(sample_reg.light_c);
        q4    = fsst_pkg::quantize(sample_reg.light_d);
        max12 = (q1 > q2) ? q1 : q2;
        max34 = (q3 > q4) ? q3 : q4;
        top   = (max12 > max34) ? max12 : max34;
        d1    = q1 < top;
        d2    = q2 < top;
        d3    = q3 < top;
        d4    = q4 < top;
    end

    // Step the angles toward the bright side, saturating at zero and the limits
    always_comb
    begin
        pan_dn = pan_pos_reg;
        if (d1 && d2 && (pan_pos_reg != '0))
        begin
            pan_dn = pan_pos_reg - 1'b1;
        end
        pan_pos_next = pan_dn;
        if (d3 && d4 && (pan_dn < pan_limit_reg))
        begin
            pan_pos_next = pan_dn + 1'b1;
        end

        tilt_up = tilt_pos_reg;
        if (d2 && d3 && (tilt_pos_reg < tilt_limit_reg))
        begin
            tilt_up = tilt_pos_reg + 1'b1;
        end
        tilt_pos_next = tilt_up;
        if (d1 && d4 && (tilt_up != '0))
        begin
            tilt_pos_next = tilt_up - 1'b1;
        end
    end

    // Hold control state and positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pan_pos_reg    <= fsst_pkg::PAN_RESET;
            tilt_pos_reg   <= fsst_pkg::TILT_RESET;
            pan_limit_reg  <= fsst_pkg::PAN_LIMIT_RESET;
            tilt_limit_reg <= fsst_pkg::TILT_LIMIT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                pan_pos_reg  <= pan_pos_next;
                tilt_pos_reg <= tilt_pos_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    fsst_pkg::CFG_PAN_LIMIT:  pan_limit_reg  <= cfg_data;
                    fsst_pkg::CFG_TILT_LIMIT: tilt_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Capture the sample set of an accepted beat
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= in_data;
        end
    end

    // Positions after the last step are the result payload
    assign out_valid           = out_valid_reg;
    assign out_data.pan_angle  = pan_pos_reg;
    assign out_data.tilt_angle = tilt_pos_reg;

endmodule

FILE: rtl/core/fsst_checker.sv
`timescale 1ns / 1ps
`include "four_sensor_sun_tracker_assert.svh"

module fsst_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_stall,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  fsst_pkg::angle_set_t                 out_data
);

    // A held result beat keeps its payload
    `FSST_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> $stable(out_data), "result payload changed while stalled")

    // Input backs up only behind a blocked result
    `FSST_ASSERT_ALWAYS(a_in_stall_cause, clk, in_stall |-> (out_valid && out_stall), "input stalled with result side free")

    // Pan moves by at most one degree per step
    `FSST_ASSERT(a_pan_step, clk, rst_n, !$stable(out_data.pan_angle) |-> (out_data.pan_angle == $past(out_data.pan_angle) + 8'd1 || out_data.pan_angle == $past(out_data.pan_angle) - 8'd1), "pan angle jumped by more than one")

    // Tilt moves by at most one degree per step
    `FSST_ASSERT(a_tilt_step, clk, rst_n, !$stable(out_data.tilt_angle) |-> (out_data.tilt_angle == $past(out_data.tilt_angle) + 8'd1 || out_data.tilt_angle == $past(out_data.tilt_angle) - 8'd1), "tilt angle jumped by more than one")

endmodule

bind four_sensor_sun_tracker fsst_checker u_fsst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
